FILE: rtl/fpsl_pkg.sv
// Package for the filtered PID speed loop: field widths, ring depths,
// fixed-point constants, register map and shared structs.
// No dependencies.
package fpsl_pkg;

    localparam int SPEED_W = 16;
    localparam int DRIVE_W = 16;
    localparam int ERR_W   = 17;
    localparam int DIF_W   = 18;
    localparam int ACC_W   = 32;
    localparam int GAIN_W  = 32;
    localparam int LIMIT_W = 31;

    // Ring depths of the two moving averages; each must be a power of two.
    localparam int IN_AVG_DEPTH  = 8;
    localparam int OUT_AVG_DEPTH = 8;
    localparam int IN_SHIFT      = $clog2(IN_AVG_DEPTH);
    localparam int OUT_SHIFT     = $clog2(OUT_AVG_DEPTH);
    localparam int IN_SLOT_W     = (IN_AVG_DEPTH > 1) ? $clog2(IN_AVG_DEPTH) : 1;
    localparam int OUT_SLOT_W    = (OUT_AVG_DEPTH > 1) ? $clog2(OUT_AVG_DEPTH) : 1;
    localparam int IN_TOT_W      = SPEED_W + IN_SLOT_W;
    localparam int OUT_TOT_W     = DRIVE_W + OUT_SLOT_W;

    // Product and sum widths.
    localparam int PPROD_W = GAIN_W + 1 + ERR_W;
    localparam int IPROD_W = GAIN_W + 1 + ACC_W;
    localparam int DPROD_W = GAIN_W + 1 + DIF_W;
    localparam int PCLAMP_W = 30;
    localparam int ICLAMP_W = 54;
    localparam int SUM_W    = 56;
    localparam int ROUND_W  = 31;

    localparam longint ONE_Q28   = 64'sd268435456;
    localparam longint ITERM_CAP = 64'sd4503599627370496;
    localparam longint Q15_MAX   = 64'sd32767;
    localparam int     Q15_SHIFT = 13;

    localparam logic [31:0] PROP_GAIN_RESET   = 32'd1881714;
    localparam logic [31:0] INTEG_GAIN_RESET  = 32'd6714;
    localparam logic [31:0] DERIV_GAIN_RESET  = 32'd4029411;
    localparam logic [30:0] INTEG_LIMIT_RESET = 31'd39984;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int PIPE_DEPTH = 6;

    typedef enum logic [1:0] {
        REG_PROP_GAIN   = 2'd0,
        REG_INTEG_GAIN  = 2'd1,
        REG_DERIV_GAIN  = 2'd2,
        REG_INTEG_LIMIT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [LIMIT_W-1:0] integ_limit;
    } cfg_t;

    typedef struct packed {
        logic err_load;
        logic prod_load;
        logic q15_load;
    } pid_ctl_t;

endpackage

FILE: rtl/fpsl_if.sv
// Valid/ready channel interfaces for the speed loop: sample in, result out.
// Depends on fpsl_pkg.
interface fpsl_sample_if;
    logic                               valid;
    logic                               ready;
    logic signed [fpsl_pkg::SPEED_W-1:0] measured_speed;
    logic signed [fpsl_pkg::SPEED_W-1:0] target_speed;
    logic                               run;

    modport source (output valid, output measured_speed, output target_speed, output run,
                    input ready);
    modport sink (input valid, input measured_speed, input target_speed, input run,
                  output ready);
endinterface

interface fpsl_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [fpsl_pkg::DRIVE_W-1:0] motor_drive;
    logic signed [fpsl_pkg::SPEED_W-1:0] filtered_speed;

    modport source (output valid, output motor_drive, output filtered_speed, input ready);
    modport sink (input valid, input motor_drive, input filtered_speed, output ready);
endinterface

FILE: rtl/fpsl_regs.sv
// APB-style configuration registers for the gains and the integral limit.
// Depends on fpsl_pkg.
module fpsl_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpsl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fpsl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fpsl_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output fpsl_pkg::cfg_t                  cfg
);

    fpsl_pkg::cfg_t     cfg_reg;
    fpsl_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = fpsl_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain   <= fpsl_pkg::PROP_GAIN_RESET;
            cfg_reg.integ_gain  <= fpsl_pkg::INTEG_GAIN_RESET;
            cfg_reg.deriv_gain  <= fpsl_pkg::DERIV_GAIN_RESET;
            cfg_reg.integ_limit <= fpsl_pkg::INTEG_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                fpsl_pkg::REG_PROP_GAIN:   cfg_reg.prop_gain   <= pwdata;
                fpsl_pkg::REG_INTEG_GAIN:  cfg_reg.integ_gain  <= pwdata;
                fpsl_pkg::REG_DERIV_GAIN:  cfg_reg.deriv_gain  <= pwdata;
                fpsl_pkg::REG_INTEG_LIMIT: cfg_reg.integ_limit <= pwdata[fpsl_pkg::LIMIT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            fpsl_pkg::REG_PROP_GAIN:   prdata = cfg_reg.prop_gain;
            fpsl_pkg::REG_INTEG_GAIN:  prdata = cfg_reg.integ_gain;
            fpsl_pkg::REG_DERIV_GAIN:  prdata = cfg_reg.deriv_gain;
            fpsl_pkg::REG_INTEG_LIMIT: prdata = {1'b0, cfg_reg.integ_limit};
        endcase
    end

endmodule

FILE: rtl/fpsl_speed_avg.sv
// Moving average of the measured speed over a ring with a running sum.
// Depends on fpsl_pkg.
module fpsl_speed_avg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic signed [fpsl_pkg::SPEED_W-1:0] measured_speed,
    input  logic signed [fpsl_pkg::SPEED_W-1:0] target_speed,
    input  logic                                run,
    output logic signed [fpsl_pkg::SPEED_W-1:0] fspeed,
    output logic signed [fpsl_pkg::SPEED_W-1:0] target,
    output logic                                run_out
);

    logic signed [fpsl_pkg::SPEED_W-1:0]  window_reg [fpsl_pkg::IN_AVG_DEPTH];
    logic [fpsl_pkg::IN_SLOT_W-1:0]       slot_reg;
    logic [fpsl_pkg::IN_SLOT_W-1:0]       slot_next;
    logic signed [fpsl_pkg::IN_TOT_W-1:0] total_reg;
    logic signed [fpsl_pkg::IN_TOT_W-1:0] total_next;
    logic signed [fpsl_pkg::IN_TOT_W-1:0] total_sel;
    logic signed [fpsl_pkg::SPEED_W-1:0]  fspeed_reg;
    logic signed [fpsl_pkg::SPEED_W-1:0]  target_reg;
    logic                                 run_reg;

    assign total_next = total_reg + fpsl_pkg::IN_TOT_W'(measured_speed)
                        - fpsl_pkg::IN_TOT_W'(window_reg[slot_reg]);
    assign slot_next  = (slot_reg == fpsl_pkg::IN_SLOT_W'(fpsl_pkg::IN_AVG_DEPTH - 1))
                        ? '0 : slot_reg + fpsl_pkg::IN_SLOT_W'(1);
    // With the loop stopped the average is reported without adding the sample.
    assign total_sel  = run ? total_next : total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fpsl_pkg::IN_AVG_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
            slot_reg  <= '0;
            total_reg <= '0;
        end
        else if (load && run)
        begin
            window_reg[slot_reg] <= measured_speed;
            slot_reg             <= slot_next;
            total_reg            <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fspeed_reg <= $signed(total_sel[fpsl_pkg::IN_SHIFT +: fpsl_pkg::SPEED_W]);
            target_reg <= target_speed;
            run_reg    <= run;
        end
    end

    assign fspeed  = fspeed_reg;
    assign target  = target_reg;
    assign run_out = run_reg;

`ifndef NO_ASSERTIONS
    a_stopped_keeps_sum: assert property (@(posedge clk) disable iff (!rst_n)
        load && !run |=> $stable(total_reg) && $stable(slot_reg))
        else $error("speed ring changed on a stopped transaction");
`endif

endmodule

FILE: rtl/fpsl_pid.sv
// PID core: error and integrator, the three gain products, then sum,
// saturation and rounding to Q1.15. Depends on fpsl_pkg.
module fpsl_pid (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fpsl_pkg::pid_ctl_t                  ctl,
    input  fpsl_pkg::cfg_t                      cfg,
    input  logic signed [fpsl_pkg::SPEED_W-1:0] fspeed_in,
    input  logic signed [fpsl_pkg::SPEED_W-1:0] target_in,
    input  logic                                run_in,
    output logic signed [fpsl_pkg::DRIVE_W-1:0] q15,
    output logic signed [fpsl_pkg::SPEED_W-1:0] fspeed_out,
    output logic                                run_out
);

    // Error stage.
    logic signed [fpsl_pkg::ERR_W-1:0] err;
    logic signed [fpsl_pkg::ACC_W:0]   acc_sum;
    logic signed [fpsl_pkg::ACC_W:0]   lim;
    logic signed [fpsl_pkg::ACC_W-1:0] acc_clamp;
    logic signed [fpsl_pkg::DIF_W-1:0] dif;
    logic signed [fpsl_pkg::DIF_W-1:0] mag;
    logic signed [fpsl_pkg::DIF_W-1:0] dif_use;
    logic signed [fpsl_pkg::ACC_W-1:0] acc_reg;
    logic signed [fpsl_pkg::ERR_W-1:0] prior_reg;

    logic signed [fpsl_pkg::ERR_W-1:0]   err_reg;
    logic signed [fpsl_pkg::ACC_W-1:0]   acc_copy_reg;
    logic signed [fpsl_pkg::DIF_W-1:0]   dif_reg;
    logic signed [fpsl_pkg::SPEED_W-1:0] fspeed2_reg;
    logic                                run2_reg;

    assign err = fpsl_pkg::ERR_W'(target_in) - fpsl_pkg::ERR_W'(fspeed_in);
    assign acc_sum = fpsl_pkg::ACC_W'(acc_reg) + (fpsl_pkg::ACC_W + 1)'(err);
    assign lim = $signed({2'b00, cfg.integ_limit});

    always_comb
    begin
        if (acc_sum > lim)
        begin
            acc_clamp = lim[fpsl_pkg::ACC_W-1:0];
        end
        else if (acc_sum < -lim)
        begin
            acc_clamp = fpsl_pkg::ACC_W'(-lim);
        end
        else
        begin
            acc_clamp = acc_sum[fpsl_pkg::ACC_W-1:0];
        end
    end

    assign dif = fpsl_pkg::DIF_W'(err) - fpsl_pkg::DIF_W'(prior_reg);
    assign mag = (err < 0) ? -fpsl_pkg::DIF_W'(err) : fpsl_pkg::DIF_W'(err);
    // A difference at least as large as the error magnitude is dropped.
    assign dif_use = (dif >= mag) ? '0 : dif;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            prior_reg <= '0;
        end
        else if (ctl.err_load)
        begin
            if (run_in)
            begin
                acc_reg   <= acc_clamp;
                prior_reg <= err;
            end
            else
            begin
                acc_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.err_load)
        begin
            err_reg      <= err;
            acc_copy_reg <= acc_clamp;
            dif_reg      <= dif_use;
            fspeed2_reg  <= fspeed_in;
            run2_reg     <= run_in;
        end
    end

    // Product stage.
    logic signed [fpsl_pkg::PPROD_W-1:0] p_prod;
    logic signed [fpsl_pkg::IPROD_W-1:0] i_prod;
    logic signed [fpsl_pkg::DPROD_W-1:0] d_prod;
    logic signed [fpsl_pkg::PPROD_W-1:0] p_prod_reg;
    logic signed [fpsl_pkg::IPROD_W-1:0] i_prod_reg;
    logic signed [fpsl_pkg::DPROD_W-1:0] d_prod_reg;
    logic signed [fpsl_pkg::SPEED_W-1:0] fspeed3_reg;
    logic                                run3_reg;

    assign p_prod = $signed({1'b0, cfg.prop_gain}) * err_reg;
    assign i_prod = $signed({1'b0, cfg.integ_gain}) * acc_copy_reg;
    assign d_prod = $signed({1'b0, cfg.deriv_gain}) * dif_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.prod_load)
        begin
            p_prod_reg  <= p_prod;
            i_prod_reg  <= i_prod;
            d_prod_reg  <= d_prod;
            fspeed3_reg <= fspeed2_reg;
            run3_reg    <= run2_reg;
        end
    end

    // Sum, saturation and rounding stage.
    logic signed [fpsl_pkg::PCLAMP_W-1:0] p_c;
    logic signed [fpsl_pkg::ICLAMP_W-1:0] i_c;
    logic signed [fpsl_pkg::SUM_W-1:0]    sum;
    logic signed [fpsl_pkg::PCLAMP_W-1:0] sum_c;
    logic signed [fpsl_pkg::ROUND_W-1:0]  rounded;
    logic signed [fpsl_pkg::ROUND_W-fpsl_pkg::Q15_SHIFT-1:0] q_wide;
    logic signed [fpsl_pkg::DRIVE_W-1:0]  q_sat;
    logic signed [fpsl_pkg::DRIVE_W-1:0]  q15_reg;
    logic signed [fpsl_pkg::SPEED_W-1:0]  fspeed4_reg;
    logic                                 run4_reg;

    always_comb
    begin
        if (p_prod_reg > fpsl_pkg::ONE_Q28)
        begin
            p_c = fpsl_pkg::PCLAMP_W'(fpsl_pkg::ONE_Q28);
        end
        else if (p_prod_reg < -fpsl_pkg::ONE_Q28)
        begin
            p_c = fpsl_pkg::PCLAMP_W'(-fpsl_pkg::ONE_Q28);
        end
        else
        begin
            p_c = p_prod_reg[fpsl_pkg::PCLAMP_W-1:0];
        end

        if (i_prod_reg > fpsl_pkg::ITERM_CAP)
        begin
            i_c = fpsl_pkg::ICLAMP_W'(fpsl_pkg::ITERM_CAP);
        end
        else if (i_prod_reg < -fpsl_pkg::ITERM_CAP)
        begin
            i_c = fpsl_pkg::ICLAMP_W'(-fpsl_pkg::ITERM_CAP);
        end
        else
        begin
            i_c = i_prod_reg[fpsl_pkg::ICLAMP_W-1:0];
        end

        sum = fpsl_pkg::SUM_W'(p_c) + fpsl_pkg::SUM_W'(i_c) + fpsl_pkg::SUM_W'(d_prod_reg);

        if (sum > fpsl_pkg::ONE_Q28)
        begin
            sum_c = fpsl_pkg::PCLAMP_W'(fpsl_pkg::ONE_Q28);
        end
        else if (sum < -fpsl_pkg::ONE_Q28)
        begin
            sum_c = fpsl_pkg::PCLAMP_W'(-fpsl_pkg::ONE_Q28);
        end
        else
        begin
            sum_c = sum[fpsl_pkg::PCLAMP_W-1:0];
        end

        // Round half up, then keep +1.0 inside the Q1.15 range.
        rounded = fpsl_pkg::ROUND_W'(sum_c) + fpsl_pkg::ROUND_W'(4096);
        q_wide  = rounded[fpsl_pkg::ROUND_W-1:fpsl_pkg::Q15_SHIFT];

        if (q_wide > fpsl_pkg::Q15_MAX)
        begin
            q_sat = fpsl_pkg::DRIVE_W'(fpsl_pkg::Q15_MAX);
        end
        else if (q_wide < -fpsl_pkg::Q15_MAX)
        begin
            q_sat = fpsl_pkg::DRIVE_W'(-fpsl_pkg::Q15_MAX);
        end
        else
        begin
            q_sat = q_wide[fpsl_pkg::DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.q15_load)
        begin
            q15_reg     <= q_sat;
            fspeed4_reg <= fspeed3_reg;
            run4_reg    <= run3_reg;
        end
    end

    assign q15        = q15_reg;
    assign fspeed_out = fspeed4_reg;
    assign run_out    = run4_reg;

`ifndef NO_ASSERTIONS
    a_stop_clears_integ: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.err_load && !run_in |=> acc_reg == '0)
        else $error("integrator not cleared on a stopped transaction");

    a_q15_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.q15_load |=> q15_reg != 16'sh8000)
        else $error("Q1.15 drive left the saturated range");
`endif

endmodule

FILE: rtl/fpsl_drive_avg.sv
// Moving average of the Q1.15 drive and the result register of the loop.
// Depends on fpsl_pkg.
module fpsl_drive_avg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic signed [fpsl_pkg::DRIVE_W-1:0] q15,
    input  logic signed [fpsl_pkg::SPEED_W-1:0] fspeed,
    input  logic                                run,
    output logic signed [fpsl_pkg::DRIVE_W-1:0] motor_drive,
    output logic signed [fpsl_pkg::SPEED_W-1:0] filtered_speed
);

    logic signed [fpsl_pkg::DRIVE_W-1:0]   window_reg [fpsl_pkg::OUT_AVG_DEPTH];
    logic [fpsl_pkg::OUT_SLOT_W-1:0]       slot_reg;
    logic [fpsl_pkg::OUT_SLOT_W-1:0]       slot_next;
    logic signed [fpsl_pkg::OUT_TOT_W-1:0] total_reg;
    logic signed [fpsl_pkg::OUT_TOT_W-1:0] total_next;
    logic signed [fpsl_pkg::DRIVE_W-1:0]   drive_reg;
    logic signed [fpsl_pkg::SPEED_W-1:0]   fspeed_reg;

    assign total_next = total_reg + fpsl_pkg::OUT_TOT_W'(q15)
                        - fpsl_pkg::OUT_TOT_W'(window_reg[slot_reg]);
    assign slot_next  = (slot_reg == fpsl_pkg::OUT_SLOT_W'(fpsl_pkg::OUT_AVG_DEPTH - 1))
                        ? '0 : slot_reg + fpsl_pkg::OUT_SLOT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fpsl_pkg::OUT_AVG_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
            slot_reg  <= '0;
            total_reg <= '0;
        end
        else if (load && run)
        begin
            window_reg[slot_reg] <= q15;
            slot_reg             <= slot_next;
            total_reg            <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg  <= run ? $signed(total_next[fpsl_pkg::OUT_SHIFT +: fpsl_pkg::DRIVE_W])
                              : '0;
            fspeed_reg <= fspeed;
        end
    end

    assign motor_drive    = drive_reg;
    assign filtered_speed = fspeed_reg;

`ifndef NO_ASSERTIONS
    a_stop_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
        load && !run |=> drive_reg == '0 && $stable(total_reg))
        else $error("stopped transaction gave a drive or moved the drive ring");
`endif

endmodule

FILE: rtl/filtered_pid_speed_loop_core.sv
// Top level of the filtered PID speed loop: channel handshakes, stage valid
// bits, and the speed average, PID and drive average stages.
// Depends on fpsl_pkg, fpsl_if, fpsl_regs, fpsl_speed_avg, fpsl_pid, fpsl_drive_avg.
//
//  Channel   Direction  Handshake        Payload
//  sample    in         valid/ready      measured_speed, target_speed, run
//  result    out        valid/ready      motor_drive, filtered_speed
//  apb       in         psel/penable     paddr, pwdata, pwrite -> prdata, pready
//
// One transaction is taken per clock while no stalled result backs up the stages;
// each running sum and the integrator update in the stage that loads their sample,
// which is what allows that rate. A result passes every stage register in order.
// Reset clears both rings, their sums and slots, the integrator and the prior error.
// Every stage holds while the next one is full, so a stalled result only stops
// the input once all six stage registers hold transactions.
module filtered_pid_speed_loop_core (
    input  logic                            clk,
    input  logic                            rst_n,
    fpsl_sample_if.sink                     sample,
    fpsl_result_if.source                   result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpsl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fpsl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fpsl_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    fpsl_pkg::cfg_t     cfg;
    fpsl_pkg::pid_ctl_t pid_ctl;

    logic [fpsl_pkg::PIPE_DEPTH-1:0] valid_reg;
    logic [fpsl_pkg::PIPE_DEPTH-1:0] stage_rdy;
    logic [fpsl_pkg::PIPE_DEPTH-1:0] stage_load;

    logic signed [fpsl_pkg::SPEED_W-1:0] meas_reg;
    logic signed [fpsl_pkg::SPEED_W-1:0] target_reg;
    logic                                run_reg;

    logic signed [fpsl_pkg::SPEED_W-1:0] s1_fspeed;
    logic signed [fpsl_pkg::SPEED_W-1:0] s1_target;
    logic                                s1_run;
    logic signed [fpsl_pkg::DRIVE_W-1:0] s4_q15;
    logic signed [fpsl_pkg::SPEED_W-1:0] s4_fspeed;
    logic                                s4_run;

    always_comb
    begin
        stage_rdy[fpsl_pkg::PIPE_DEPTH-1] = !valid_reg[fpsl_pkg::PIPE_DEPTH-1] || result.ready;
        for (int k = fpsl_pkg::PIPE_DEPTH - 2; k >= 0; k--)
        begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
        stage_load[0] = sample.valid && stage_rdy[0];
        for (int k = 1; k < fpsl_pkg::PIPE_DEPTH; k++)
        begin
            stage_load[k] = valid_reg[k-1] && stage_rdy[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_rdy[0])
            begin
                valid_reg[0] <= sample.valid;
            end
            for (int k = 1; k < fpsl_pkg::PIPE_DEPTH; k++)
            begin
                if (stage_rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[0])
        begin
            meas_reg   <= sample.measured_speed;
            target_reg <= sample.target_speed;
            run_reg    <= sample.run;
        end
    end

    assign sample.ready = stage_rdy[0];
    assign result.valid = valid_reg[fpsl_pkg::PIPE_DEPTH-1];

    assign pid_ctl.err_load  = stage_load[2];
    assign pid_ctl.prod_load = stage_load[3];
    assign pid_ctl.q15_load  = stage_load[4];

    fpsl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpsl_speed_avg u_speed_avg (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (stage_load[1]),
        .measured_speed (meas_reg),
        .target_speed   (target_reg),
        .run            (run_reg),
        .fspeed         (s1_fspeed),
        .target         (s1_target),
        .run_out        (s1_run)
    );

    fpsl_pid u_pid (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (pid_ctl),
        .cfg        (cfg),
        .fspeed_in  (s1_fspeed),
        .target_in  (s1_target),
        .run_in     (s1_run),
        .q15        (s4_q15),
        .fspeed_out (s4_fspeed),
        .run_out    (s4_run)
    );

    fpsl_drive_avg u_drive_avg (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (stage_load[5]),
        .q15            (s4_q15),
        .fspeed         (s4_fspeed),
        .run            (s4_run),
        .motor_drive    (result.motor_drive),
        .filtered_speed (result.filtered_speed)
    );

`ifndef NO_ASSERTIONS
    a_full_pipe_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !result.ready |-> !sample.ready)
        else $error("input taken while every stage is full and the output stalls");
`endif

endmodule

FILE: tb/tb_filtered_pid_speed_loop_core.sv
// Self-checking testbench for filtered_pid_speed_loop_core: random bursts of speed samples,
// an independent loop predictor, result checking and register setup over APB.
// Depends on fpsl_pkg, fpsl_if and the RTL of the core.
module tb_filtered_pid_speed_loop_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [fpsl_pkg::SPEED_W-1:0] meas;
        logic signed [fpsl_pkg::SPEED_W-1:0] target;
        logic                                run;
    } speed_sample_t;

    typedef struct {
        logic signed [fpsl_pkg::DRIVE_W-1:0] drive;
        logic signed [fpsl_pkg::SPEED_W-1:0] speed;
    } loop_result_t;

    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [fpsl_pkg::APB_ADDR_W-1:0] paddr;
    logic [fpsl_pkg::APB_DATA_W-1:0] pwdata;
    logic [fpsl_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    fpsl_sample_if sample_ch();
    fpsl_result_if result_ch();

    filtered_pid_speed_loop_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: a copy of the registers, both rings and the PID memory.
    fpsl_pkg::cfg_t                        gain_shadow;
    logic signed [fpsl_pkg::SPEED_W-1:0]   speed_ring [fpsl_pkg::IN_AVG_DEPTH];
    logic [fpsl_pkg::IN_SLOT_W-1:0]        speed_pos;
    logic signed [fpsl_pkg::IN_TOT_W-1:0]  speed_sum;
    logic signed [fpsl_pkg::DRIVE_W-1:0]   drive_ring [fpsl_pkg::OUT_AVG_DEPTH];
    logic [fpsl_pkg::OUT_SLOT_W-1:0]       drive_pos;
    logic signed [fpsl_pkg::OUT_TOT_W-1:0] drive_sum;
    logic signed [fpsl_pkg::ACC_W-1:0]     err_accum;
    logic signed [fpsl_pkg::ERR_W-1:0]     last_err;

    speed_sample_t samples_pending[$];
    loop_result_t  results_due[$];
    loop_result_t  due;
    int            mismatches;
    int            results_checked;

    int            burst_left;
    int            gap_left;
    ready_mode_t   stall_mode;
    int            mode_left;
    int            tick;
    int            hold_left;
    bit            held_off;

    function automatic longint limit_to(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic loop_result_t predict_loop_step(
        logic signed [fpsl_pkg::SPEED_W-1:0] meas,
        logic signed [fpsl_pkg::SPEED_W-1:0] target,
        logic run);
        loop_result_t r;
        longint tot, err, gp, gi, gd, lim, pterm, acc, iterm, dif, mag, dterm, sum, q15;
        if (!run)
        begin
            err_accum = '0;
            r.speed = longint'(speed_sum) >>> fpsl_pkg::IN_SHIFT;
            r.drive = '0;
        end
        else
        begin
            tot = longint'(speed_sum) + longint'(meas) - longint'(speed_ring[speed_pos]);
            speed_sum = tot;
            speed_ring[speed_pos] = meas;
            speed_pos = speed_pos + 1'b1;
            r.speed = tot >>> fpsl_pkg::IN_SHIFT;

            err = longint'(target) - (tot >>> fpsl_pkg::IN_SHIFT);
            gp = {32'd0, gain_shadow.prop_gain};
            gi = {32'd0, gain_shadow.integ_gain};
            gd = {32'd0, gain_shadow.deriv_gain};
            lim = {33'd0, gain_shadow.integ_limit};

            pterm = limit_to(gp * err, -fpsl_pkg::ONE_Q28, fpsl_pkg::ONE_Q28);
            acc = limit_to(longint'(err_accum) + err, -lim, lim);
            err_accum = acc;
            iterm = limit_to(gi * acc, -fpsl_pkg::ITERM_CAP, fpsl_pkg::ITERM_CAP);

            // A derivative that grows at least as fast as the error itself is dropped.
            dif = err - longint'(last_err);
            mag = (err < 0) ? -err : err;
            if (dif >= mag)
                dif = 0;
            dterm = gd * dif;
            last_err = err;

            sum = limit_to(pterm + iterm + dterm, -fpsl_pkg::ONE_Q28, fpsl_pkg::ONE_Q28);
            q15 = limit_to((sum + (longint'(1) <<< (fpsl_pkg::Q15_SHIFT - 1)))
                           >>> fpsl_pkg::Q15_SHIFT,
                           -fpsl_pkg::Q15_MAX, fpsl_pkg::Q15_MAX);

            tot = longint'(drive_sum) + q15 - longint'(drive_ring[drive_pos]);
            drive_sum = tot;
            drive_ring[drive_pos] = q15;
            drive_pos = drive_pos + 1'b1;
            r.drive = tot >>> fpsl_pkg::OUT_SHIFT;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task automatic push_item(int meas, int target, bit run);
        speed_sample_t s;
        s.meas = limit_to(meas, -32768, 32767);
        s.target = limit_to(target, -32768, 32767);
        s.run = run;
        samples_pending.push_back(s);
    endtask

    // Mostly steady-target runs with the speed settling toward the target,
    // mixed with short bursts of full-range noise.
    task automatic gen_traffic(int count);
        int made, seg, span, tgt, spd;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                seg = $urandom_range(6, 40);
                span = ($urandom_range(0, 3) == 0) ? 32767 : 3000;
                tgt = int'($urandom_range(0, 2 * span)) - span;
                spd = tgt + int'($urandom_range(0, 1200)) - 600;
                repeat (seg)
                begin
                    push_item(spd, tgt, $urandom_range(0, 30) != 0);
                    spd = limit_to(spd + (tgt - spd) / 4 + int'($urandom_range(0, 80)) - 40,
                                   -32768, 32767);
                    made++;
                end
            end
            else
            begin
                seg = $urandom_range(1, 6);
                repeat (seg)
                begin
                    push_item(int'($urandom_range(0, 65535)) - 32768,
                              int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 1));
                    made++;
                end
            end
        end
    endtask

    task automatic apb_write(fpsl_pkg::reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            fpsl_pkg::REG_PROP_GAIN:   gain_shadow.prop_gain = value;
            fpsl_pkg::REG_INTEG_GAIN:  gain_shadow.integ_gain = value;
            fpsl_pkg::REG_DERIV_GAIN:  gain_shadow.deriv_gain = value;
            fpsl_pkg::REG_INTEG_LIMIT: gain_shadow.integ_limit = value[fpsl_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                                 logic [31:0] lim);
        apb_write(fpsl_pkg::REG_PROP_GAIN, p);
        apb_write(fpsl_pkg::REG_INTEG_GAIN, i);
        apb_write(fpsl_pkg::REG_DERIV_GAIN, d);
        apb_write(fpsl_pkg::REG_INTEG_LIMIT, lim);
    endtask

    task automatic wait_idle();
        while (samples_pending.size() != 0 || results_due.size() != 0)
            @(posedge clk);
        repeat (fpsl_pkg::PIPE_DEPTH + 4) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4ms;
        $display("tb_filtered_pid_speed_loop_core failed");
        $finish;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                results_due.push_back(predict_loop_step(sample_ch.measured_speed,
                                                        sample_ch.target_speed, sample_ch.run));
                void'(samples_pending.pop_front());
            end
            if (!(sample_ch.valid && !sample_ch.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sample_ch.valid <= 1'b0;
                end
                else if (samples_pending.size() != 0)
                begin
                    sample_ch.valid <= 1'b1;
                    sample_ch.measured_speed <= samples_pending[0].meas;
                    sample_ch.target_speed <= samples_pending[0].target;
                    sample_ch.run <= samples_pending[0].run;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switches between stall patterns, and holds off once for a long
    // stretch so that the pipeline fills and backs up into the sample channel.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left = 0;
            held_off = 1'b0;
            mode_left = 0;
            tick = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (!held_off && results_checked >= 250)
        begin
            held_off = 1'b1;
            hold_left = 90;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = ready_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(4, 50);
                tick = 0;
            end
            mode_left--;
            tick++;
            case (stall_mode)
                READY_ALWAYS: result_ch.ready <= 1'b1;
                READY_COIN:   result_ch.ready <= $urandom_range(0, 1);
                default:      result_ch.ready <= (tick % 3 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (results_due.size() == 0)
            begin
                report_mismatch("result transaction with no sample outstanding");
            end
            else
            begin
                due = results_due.pop_front();
                if (result_ch.motor_drive !== due.drive)
                    report_mismatch($sformatf("motor_drive got %0d, expected %0d",
                                              result_ch.motor_drive, due.drive));
                if (result_ch.filtered_speed !== due.speed)
                    report_mismatch($sformatf("filtered_speed got %0d, expected %0d",
                                              result_ch.filtered_speed, due.speed));
                results_checked++;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.measured_speed = '0;
        sample_ch.target_speed = '0;
        sample_ch.run = 1'b0;
        result_ch.ready = 1'b0;
        mismatches = 0;
        results_checked = 0;
        gain_shadow.prop_gain = fpsl_pkg::PROP_GAIN_RESET;
        gain_shadow.integ_gain = fpsl_pkg::INTEG_GAIN_RESET;
        gain_shadow.deriv_gain = fpsl_pkg::DERIV_GAIN_RESET;
        gain_shadow.integ_limit = fpsl_pkg::INTEG_LIMIT_RESET;
        foreach (speed_ring[k])
            speed_ring[k] = '0;
        foreach (drive_ring[k])
            drive_ring[k] = '0;
        speed_pos = '0;
        speed_sum = '0;
        drive_pos = '0;
        drive_sum = '0;
        err_accum = '0;
        last_err = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset gains: stopped loop, both saturation directions, negative averages
        // that round down, and a stop in the middle of a run.
        push_item(0, 0, 0);
        push_item(-32768, 32767, 0);
        repeat (4) push_item(32767, -32768, 1);
        repeat (4) push_item(-32768, 32767, 1);
        push_item(32767, 32767, 0);
        push_item(-1, 0, 1);
        push_item(-3, -5, 1);
        repeat (2) push_item(0, 0, 1);
        push_item(32767, 32767, 0);
        repeat (3) push_item(100, 120, 1);
        gen_traffic(110);
        wait_idle();

        // Largest gains and limit: the P term and the sum saturate, the integral hits its cap.
        program_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        push_item(0, 32767, 1);
        push_item(0, -32768, 1);
        push_item(-32768, -32768, 1);
        gen_traffic(100);
        wait_idle();

        // All gains and the integral limit at zero.
        program_gains(32'd0, 32'd0, 32'd0, 32'd0);
        gen_traffic(80);
        wait_idle();

        // Small gains and a tight integral limit.
        program_gains($urandom_range(0, 1 << 22), $urandom_range(0, 1 << 18),
                      $urandom_range(0, 1 << 22), $urandom_range(0, 5000));
        gen_traffic(120);
        wait_idle();

        // Integral only, with a large gain and the widest limit.
        program_gains(32'd0, $urandom_range(1 << 20, 32'hFFFF_FFFF), 32'd0, 32'h7FFF_FFFF);
        gen_traffic(100);
        wait_idle();

        program_gains($urandom, $urandom, $urandom, $urandom & 32'h7FFF_FFFF);
        gen_traffic(140);
        wait_idle();

        if (mismatches == 0 && results_due.size() == 0)
            $display("tb_filtered_pid_speed_loop_core passed");
        else
            $display("tb_filtered_pid_speed_loop_core failed");
        $finish;
    end

endmodule
